// ===== rtl/i2cra_pkg.sv =====
package i2cra_pkg;

	// One bus phase tick coming in
	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  slave_addr;
		logic [15:0] reg_addr;
		logic [7:0]  write_value;
		logic        sda_in;
	} i2cra_in_t;

	// Line levels and status for the same tick
	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] read_data;
	} i2cra_out_t;

	// One entry of a command program: bus segment and byte source
	typedef struct packed {
		logic [2:0] seg;
		logic [2:0] sel;
	} i2cra_entry_t;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PROBE = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [2:0] SEG_START = 3'd0;
	localparam logic [2:0] SEG_WRITE = 3'd1;
	localparam logic [2:0] SEG_ACK   = 3'd2;
	localparam logic [2:0] SEG_READ  = 3'd3;
	localparam logic [2:0] SEG_NACK  = 3'd4;
	localparam logic [2:0] SEG_STOP  = 3'd5;

	localparam logic [2:0] SEL_ADDR_WR = 3'd0;
	localparam logic [2:0] SEL_REG_HI  = 3'd1;
	localparam logic [2:0] SEL_REG_LO  = 3'd2;
	localparam logic [2:0] SEL_DATA    = 3'd3;
	localparam logic [2:0] SEL_ADDR_RD = 3'd4;

	localparam logic [1:0] PROG_PROBE = 2'd0;
	localparam logic [1:0] PROG_WRITE = 2'd1;
	localparam logic [1:0] PROG_READ  = 2'd2;

	localparam logic [2:0]  ADDR_ACK_TIMEOUT = 3'd0;
	localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd100;

	function automatic i2cra_entry_t mk_entry(input logic [2:0] seg, input logic [2:0] sel);
		i2cra_entry_t e;
		e.seg = seg;
		e.sel = sel;
		return e;
	endfunction

	// Index of the final (stop) entry of each program
	function automatic logic [3:0] prog_last(input logic [1:0] prog);
		logic [3:0] r;
		unique case (prog)
			PROG_PROBE: r = 4'd3;
			PROG_WRITE: r = 4'd9;
			default:    r = 4'd12;
		endcase
		return r;
	endfunction

	function automatic i2cra_entry_t prog_entry(input logic [1:0] prog, input logic [3:0] pc);
		i2cra_entry_t e;
		e = mk_entry(SEG_START, SEL_ADDR_WR);
		unique case (prog)
			PROG_PROBE: begin
				case (pc)
					4'd1:    e = mk_entry(SEG_WRITE, SEL_ADDR_WR);
					4'd2:    e = mk_entry(SEG_ACK, SEL_ADDR_WR);
					4'd3:    e = mk_entry(SEG_STOP, SEL_ADDR_WR);
					default: e = mk_entry(SEG_START, SEL_ADDR_WR);
				endcase
			end
			PROG_WRITE: begin
				case (pc)
					4'd1:                e = mk_entry(SEG_WRITE, SEL_ADDR_WR);
					4'd3:                e = mk_entry(SEG_WRITE, SEL_REG_HI);
					4'd5:                e = mk_entry(SEG_WRITE, SEL_REG_LO);
					4'd7:                e = mk_entry(SEG_WRITE, SEL_DATA);
					4'd2, 4'd4, 4'd6, 4'd8: e = mk_entry(SEG_ACK, SEL_ADDR_WR);
					4'd9:                e = mk_entry(SEG_STOP, SEL_ADDR_WR);
					default:             e = mk_entry(SEG_START, SEL_ADDR_WR);
				endcase
			end
			default: begin
				case (pc)
					4'd1:                e = mk_entry(SEG_WRITE, SEL_ADDR_WR);
					4'd3:                e = mk_entry(SEG_WRITE, SEL_REG_HI);
					4'd5:                e = mk_entry(SEG_WRITE, SEL_REG_LO);
					4'd8:                e = mk_entry(SEG_WRITE, SEL_ADDR_RD);
					4'd2, 4'd4, 4'd6, 4'd9: e = mk_entry(SEG_ACK, SEL_ADDR_WR);
					4'd10:               e = mk_entry(SEG_READ, SEL_ADDR_WR);
					4'd11:               e = mk_entry(SEG_NACK, SEL_ADDR_WR);
					4'd12:               e = mk_entry(SEG_STOP, SEL_ADDR_WR);
					default:             e = mk_entry(SEG_START, SEL_ADDR_WR);
				endcase
			end
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/i2cra_seq.sv =====
module i2cra_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  i2cra_pkg::i2cra_in_t  item,
	input  logic [15:0]           ack_timeout,
	output i2cra_pkg::i2cra_out_t res
);
	import i2cra_pkg::*;

	logic [4:0]  step_q, n_step;
	logic [1:0]  phase_q, n_phase;
	logic [2:0]  bit_q, n_bit;
	logic [2:0]  byte_q, n_byte;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] wait_q, n_wait;
	logic [1:0]  hkind_q, n_hkind;
	logic [6:0]  hslave_q, n_hslave;
	logic [15:0] hreg_q, n_hreg;
	logic [7:0]  hval_q, n_hval;
	logic [7:0]  cap_q, n_cap;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        oe_q, n_oe;
	logic        status_q, n_status;
	logic        n_done;

	always_comb begin
		logic [1:0]   prog;
		logic [4:0]   pc;
		logic [3:0]   last;
		i2cra_entry_t ent;
		logic [7:0]   pick;

		n_step   = step_q;
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_byte   = byte_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_hkind  = hkind_q;
		n_hslave = hslave_q;
		n_hreg   = hreg_q;
		n_hval   = hval_q;
		n_cap    = cap_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_oe     = oe_q;
		n_status = status_q;
		n_done   = 1'b0;

		// take a command only when idle; the sequencer starts on the same tick
		if (step_q == 5'd0 && item.kind != KIND_NONE) begin
			n_hkind  = item.kind;
			n_hslave = item.slave_addr;
			n_hreg   = item.reg_addr;
			n_hval   = item.write_value;
			n_status = 1'b0;
			n_step   = 5'd1;
			n_phase  = 2'd0;
			n_bit    = 3'd0;
		end

		prog = (n_hkind == KIND_NONE) ? PROG_PROBE : n_hkind - 2'd1;
		last = prog_last(prog);
		pc   = n_step - 5'd1;
		if (pc > {1'b0, last})
			pc = {1'b0, last};
		ent = prog_entry(prog, pc[3:0]);

		case (ent.sel)
			SEL_ADDR_WR: pick = {n_hslave, 1'b0};
			SEL_REG_HI:  pick = n_hreg[15:8];
			SEL_REG_LO:  pick = n_hreg[7:0];
			SEL_DATA:    pick = n_hval;
			default:     pick = {n_hslave, 1'b1};
		endcase

		if (n_step != 5'd0) begin
			unique case (ent.seg)
				SEG_START: begin
					case (n_phase)
						2'd0: n_phase = 2'd1;
						2'd1: begin
							n_oe = 1'b1; n_sda = 1'b1; n_scl = 1'b1; n_phase = 2'd2;
						end
						2'd2: begin
							n_sda = 1'b0; n_phase = 2'd3;
						end
						default: begin
							n_scl = 1'b0; n_step = n_step + 5'd1; n_phase = 2'd0; n_bit = 3'd0;
						end
					endcase
				end
				SEG_WRITE: begin
					case (n_phase)
						2'd0: begin
							n_byte = ent.sel; n_shift = pick; n_bit = 3'd0; n_phase = 2'd1;
						end
						2'd1: begin
							n_oe = 1'b1; n_sda = n_shift[7]; n_phase = 2'd2;
						end
						2'd2: begin
							n_scl = 1'b1; n_phase = 2'd3;
						end
						default: begin
							n_scl = 1'b0;
							if (n_bit == 3'd7) begin
								n_sda = 1'b1; n_step = n_step + 5'd1; n_phase = 2'd0; n_bit = 3'd0;
							end else begin
								n_shift = {n_shift[6:0], 1'b0}; n_bit = n_bit + 3'd1; n_phase = 2'd1;
							end
						end
					endcase
				end
				SEG_ACK: begin
					case (n_phase)
						2'd0: n_phase = 2'd1;
						2'd1: begin
							n_scl = 1'b1; n_wait = ack_timeout; n_phase = 2'd2;
						end
						2'd2: begin
							n_oe = 1'b0;
							if (n_wait == 16'd0) begin
								n_status = 1'b1; n_phase = 2'd3;
							end else if (!item.sda_in) begin
								n_phase = 2'd3;
							end else begin
								n_wait = n_wait - 16'd1;
							end
						end
						default: begin
							n_scl = 1'b0;
							// missing acknowledge: jump to the stop entry
							if (n_status)
								n_step = {1'b0, last} + 5'd1;
							else
								n_step = n_step + 5'd1;
							n_phase = 2'd0;
							n_bit   = 3'd0;
						end
					endcase
				end
				SEG_READ: begin
					case (n_phase)
						2'd0: begin
							n_shift = 8'd0; n_bit = 3'd0; n_phase = 2'd1;
						end
						2'd1: begin
							n_oe = 1'b0; n_scl = 1'b1; n_phase = 2'd2;
						end
						2'd2: begin
							n_shift = {n_shift[6:0], item.sda_in}; n_phase = 2'd3;
						end
						default: begin
							n_scl = 1'b0;
							if (n_bit == 3'd7) begin
								n_cap = n_shift; n_step = n_step + 5'd1; n_phase = 2'd0; n_bit = 3'd0;
							end else begin
								n_bit = n_bit + 3'd1; n_phase = 2'd1;
							end
						end
					endcase
				end
				SEG_NACK: begin
					case (n_phase)
						2'd0: n_phase = 2'd1;
						2'd1: begin
							n_oe = 1'b1; n_sda = 1'b1; n_phase = 2'd2;
						end
						2'd2: begin
							n_scl = 1'b1; n_phase = 2'd3;
						end
						default: begin
							n_scl = 1'b0; n_step = n_step + 5'd1; n_phase = 2'd0; n_bit = 3'd0;
						end
					endcase
				end
				default: begin
					case (n_phase)
						2'd0: n_phase = 2'd1;
						2'd1: begin
							n_oe = 1'b1; n_sda = 1'b0; n_phase = 2'd2;
						end
						2'd2: begin
							n_scl = 1'b1; n_phase = 2'd3;
						end
						default: begin
							n_sda = 1'b1; n_done = 1'b1;
							n_step = 5'd0; n_phase = 2'd0; n_bit = 3'd0;
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= 5'd0;
			phase_q  <= 2'd0;
			bit_q    <= 3'd0;
			byte_q   <= 3'd0;
			shift_q  <= 8'd0;
			wait_q   <= 16'd0;
			hkind_q  <= KIND_NONE;
			hslave_q <= 7'd0;
			hreg_q   <= 16'd0;
			hval_q   <= 8'd0;
			cap_q    <= 8'd0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			oe_q     <= 1'b1;
			status_q <= 1'b0;
		end else if (fire) begin
			step_q   <= n_step;
			phase_q  <= n_phase;
			bit_q    <= n_bit;
			byte_q   <= n_byte;
			shift_q  <= n_shift;
			wait_q   <= n_wait;
			hkind_q  <= n_hkind;
			hslave_q <= n_hslave;
			hreg_q   <= n_hreg;
			hval_q   <= n_hval;
			cap_q    <= n_cap;
			scl_q    <= n_scl;
			sda_q    <= n_sda;
			oe_q     <= n_oe;
			status_q <= n_status;
		end
	end

	always_comb begin
		res.scl        = n_scl;
		res.sda_level  = n_sda;
		res.sda_enable = n_oe;
		res.busy_res   = (n_step != 5'd0);
		res.done_res   = n_done;
		res.status     = n_status;
		res.read_data  = n_cap;
	end

endmodule

// ===== rtl/i2c_master_register_access_core.sv =====
// An accepted input transfer passes through the input register, then the
// sequencer step into the output register, before its result transfer.
// Throughput: one tick per cycle while the result side does not stall.
// Reset (arst_n low, asynchronous): sequencer idle, SCL/SDA released high with
// SDA driven, status and read data cleared, ack_timeout back to 100.
module i2c_master_register_access_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cra_pkg::i2cra_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cra_pkg::i2cra_out_t out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import i2cra_pkg::*;

	logic        s1_valid_q;
	i2cra_in_t   item_s1;
	logic        out_valid_q;
	i2cra_out_t  out_s2;
	i2cra_out_t  res;
	logic        adv;
	logic [15:0] ack_timeout_q;
	logic        reg_hit;

	// Configuration: one register, word aligned; the low two address bits are ignored.
	assign pready  = 1'b1;
	assign reg_hit = ({paddr[2], 2'b00} == ADDR_ACK_TIMEOUT);
	assign prdata  = reg_hit ? {16'd0, ack_timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ack_timeout_q <= ACK_TIMEOUT_RST;
		else if (psel && penable && pwrite && pready && reg_hit)
			ack_timeout_q <= pwdata[15:0];
	end

	// Step the sequencer whenever the input register holds a tick and the
	// output register is empty or being drained this cycle.
	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	// Stall the source only when the held tick cannot move on.
	assign in_stall = s1_valid_q && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (!in_stall)
			s1_valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	i2cra_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.item        (item_s1),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

	// Output register: load on a step, drop valid once the result transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_s2 <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_s2;

endmodule

// ===== rtl/i2cra_checker.sv =====
module i2cra_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input i2cra_pkg::i2cra_in_t  in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input i2cra_pkg::i2cra_out_t out_data,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [2:0]            paddr,
	input logic [31:0]           pwdata,
	input logic [31:0]           prdata,
	input logic                  pready
);
	import i2cra_pkg::*;

	// Hold a stalled tick on the input side.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input transfer changed");

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result transfer changed");

	// Empty output register means the input side is never stalled.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// Finishing tick ends the transaction with both lines released and SDA driven.
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |->
			!out_data.busy_res && out_data.scl && out_data.sda_level && out_data.sda_enable)
		else $error("done pulse with wrong line levels or busy");

	// A register write reads back.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2]
			|=> !paddr[2] || prdata[15:0] == $past(pwdata[15:0]))
		else $error("ack_timeout readback mismatch");

endmodule

bind i2c_master_register_access_core i2cra_checker u_i2cra_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import i2cra_pkg::*;

	// How a simulated target answers on SDA while the master listens
	typedef enum logic [1:0] {
		ACK_EAGER,
		ACK_MIXED,
		ACK_LAZY,
		ACK_NONE
	} sda_habit_t;

	localparam logic [2:0] REG_SPARE = 3'd4;  // first address past the register list

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	i2cra_in_t   in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	i2cra_out_t  out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	i2c_master_register_access_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Bus ticks waiting to be driven, and line levels waiting to be seen
	i2cra_in_t  pending_ticks[$];
	i2cra_out_t line_expect[$];

	int queued = 0;   // ticks handed to the driver
	int taken = 0;    // ticks accepted by the block
	int checked = 0;  // result transfers compared
	int faults = 0;

	// Handshake pacing
	bit in_fire = 1'b0;
	bit calm = 1'b0;
	int idle_pct = 0;
	int stall_pct = 0;
	int in_gap = 0;
	int stall_left = 0;

	// Shadow of the sequencer, lines and register
	logic [4:0]  seq_step = '0;
	logic [1:0]  seq_phase = '0;
	logic [2:0]  bit_pos = '0;
	logic [7:0]  shifter = '0;
	logic [15:0] ack_left = '0;
	logic [1:0]  cmd_kind = KIND_NONE;
	logic [6:0]  cmd_slave = '0;
	logic [15:0] cmd_reg = '0;
	logic [7:0]  cmd_value = '0;
	logic [7:0]  rx_byte = '0;
	logic        drv_scl = 1'b1;
	logic        drv_sda = 1'b1;
	logic        drv_oe = 1'b1;
	logic        nak_seen = 1'b0;
	logic [15:0] ack_limit = ACK_TIMEOUT_RST;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Slot of the final stop segment for each command
	function automatic logic [3:0] stop_slot(input logic [1:0] k);
		case (k)
			KIND_WRITE: return 4'd9;
			KIND_READ:  return 4'd12;
			default:    return 4'd3;
		endcase
	endfunction

	// Segment and byte source at slot pc of the command's bus sequence
	function automatic void program_slot(input logic [1:0] k, input logic [4:0] pc,
			output logic [2:0] seg, output logic [2:0] src);
		seg = SEG_START;
		src = SEL_ADDR_WR;
		if (pc == {1'b0, stop_slot(k)}) begin
			seg = SEG_STOP;
		end else if (k == KIND_PROBE || k == KIND_NONE) begin
			if (pc == 5'd1) seg = SEG_WRITE;
			else if (pc == 5'd2) seg = SEG_ACK;
		end else begin
			case (pc)
				5'd1: seg = SEG_WRITE;
				5'd3: begin
					seg = SEG_WRITE;
					src = SEL_REG_HI;
				end
				5'd5: begin
					seg = SEG_WRITE;
					src = SEL_REG_LO;
				end
				5'd2, 5'd4, 5'd6: seg = SEG_ACK;
				default: ;
			endcase
			// the write and read sequences part ways after the register low byte
			if (k == KIND_WRITE) begin
				if (pc == 5'd7) begin
					seg = SEG_WRITE;
					src = SEL_DATA;
				end else if (pc == 5'd8) begin
					seg = SEG_ACK;
				end
			end else begin
				case (pc)
					5'd8: begin
						seg = SEG_WRITE;
						src = SEL_ADDR_RD;
					end
					5'd9:  seg = SEG_ACK;
					5'd10: seg = SEG_READ;
					5'd11: seg = SEG_NACK;
					default: ;
				endcase
			end
		end
	endfunction

	function automatic logic [7:0] outgoing_byte(input logic [2:0] src);
		case (src)
			SEL_ADDR_WR: return {cmd_slave, 1'b0};
			SEL_REG_HI:  return cmd_reg[15:8];
			SEL_REG_LO:  return cmd_reg[7:0];
			SEL_DATA:    return cmd_value;
			default:     return {cmd_slave, 1'b1};
		endcase
	endfunction

	task automatic next_segment();
		seq_step = seq_step + 5'd1;
		seq_phase = 2'd0;
		bit_pos = 3'd0;
	endtask

	// Advance the shadow sequencer by one tick and report the lines it drives
	task automatic bus_tick(input i2cra_in_t t, output i2cra_out_t r);
		logic [4:0] pc;
		logic [2:0] seg;
		logic [2:0] src;
		logic       fin;
		fin = 1'b0;
		if (seq_step == 5'd0 && t.kind != KIND_NONE) begin
			cmd_kind = t.kind;
			cmd_slave = t.slave_addr;
			cmd_reg = t.reg_addr;
			cmd_value = t.write_value;
			nak_seen = 1'b0;
			seq_step = 5'd1;
			seq_phase = 2'd0;
			bit_pos = 3'd0;
		end
		if (seq_step != 5'd0) begin
			pc = seq_step - 5'd1;
			if (pc > {1'b0, stop_slot(cmd_kind)}) pc = {1'b0, stop_slot(cmd_kind)};
			program_slot(cmd_kind, pc, seg, src);
			case (seg)
				SEG_START: begin
					if (seq_phase == 2'd3) begin
						drv_scl = 1'b0;
						next_segment();
					end else begin
						if (seq_phase == 2'd1) begin
							drv_oe = 1'b1;
							drv_sda = 1'b1;
							drv_scl = 1'b1;
						end else if (seq_phase == 2'd2) begin
							drv_sda = 1'b0;
						end
						seq_phase = seq_phase + 2'd1;
					end
				end
				SEG_WRITE: begin
					case (seq_phase)
						2'd0: begin
							shifter = outgoing_byte(src);
							bit_pos = 3'd0;
							seq_phase = 2'd1;
						end
						2'd1: begin
							drv_oe = 1'b1;
							drv_sda = shifter[7];
							seq_phase = 2'd2;
						end
						2'd2: begin
							drv_scl = 1'b1;
							seq_phase = 2'd3;
						end
						default: begin
							drv_scl = 1'b0;
							if (bit_pos == 3'd7) begin
								drv_sda = 1'b1;  // release SDA for the acknowledge
								next_segment();
							end else begin
								shifter = shifter << 1;
								bit_pos = bit_pos + 3'd1;
								seq_phase = 2'd1;
							end
						end
					endcase
				end
				SEG_ACK: begin
					case (seq_phase)
						2'd0: seq_phase = 2'd1;
						2'd1: begin
							drv_scl = 1'b1;
							ack_left = ack_limit;
							seq_phase = 2'd2;
						end
						2'd2: begin
							// hold SCL high until the target pulls SDA low or time runs out
							drv_oe = 1'b0;
							if (ack_left == 16'd0) begin
								nak_seen = 1'b1;
								seq_phase = 2'd3;
							end else if (!t.sda_in) begin
								seq_phase = 2'd3;
							end else begin
								ack_left = ack_left - 16'd1;
							end
						end
						default: begin
							drv_scl = 1'b0;
							if (nak_seen) begin
								// a missing acknowledge jumps straight to the stop
								seq_step = {1'b0, stop_slot(cmd_kind)} + 5'd1;
								seq_phase = 2'd0;
								bit_pos = 3'd0;
							end else begin
								next_segment();
							end
						end
					endcase
				end
				SEG_READ: begin
					case (seq_phase)
						2'd0: begin
							shifter = 8'd0;
							bit_pos = 3'd0;
							seq_phase = 2'd1;
						end
						2'd1: begin
							drv_oe = 1'b0;
							drv_scl = 1'b1;
							seq_phase = 2'd2;
						end
						2'd2: begin
							shifter = {shifter[6:0], t.sda_in};
							seq_phase = 2'd3;
						end
						default: begin
							drv_scl = 1'b0;
							if (bit_pos == 3'd7) begin
								rx_byte = shifter;
								next_segment();
							end else begin
								bit_pos = bit_pos + 3'd1;
								seq_phase = 2'd1;
							end
						end
					endcase
				end
				SEG_NACK: begin
					if (seq_phase == 2'd3) begin
						drv_scl = 1'b0;
						next_segment();
					end else begin
						if (seq_phase == 2'd1) begin
							drv_oe = 1'b1;
							drv_sda = 1'b1;
						end else if (seq_phase == 2'd2) begin
							drv_scl = 1'b1;
						end
						seq_phase = seq_phase + 2'd1;
					end
				end
				default: begin
					if (seq_phase == 2'd3) begin
						drv_sda = 1'b1;
						fin = 1'b1;
						seq_step = 5'd0;
						seq_phase = 2'd0;
						bit_pos = 3'd0;
					end else begin
						if (seq_phase == 2'd1) begin
							drv_oe = 1'b1;
							drv_sda = 1'b0;
						end else if (seq_phase == 2'd2) begin
							drv_scl = 1'b1;
						end
						seq_phase = seq_phase + 2'd1;
					end
				end
			endcase
		end
		r.scl = drv_scl;
		r.sda_level = drv_sda;
		r.sda_enable = drv_oe;
		r.busy_res = (seq_step != 5'd0);
		r.done_res = fin;
		r.status = nak_seen;
		r.read_data = rx_byte;
	endtask

	task automatic flag(input string what, input logic [31:0] e, input logic [31:0] a);
		faults++;
		$display("%0d ns: %s expected %0h, got %0h", $time, what, e, a);
	endtask

	task automatic check_line(input i2cra_out_t w, input i2cra_out_t g);
		if (g.scl !== w.scl) flag("scl", 32'(w.scl), 32'(g.scl));
		if (g.sda_level !== w.sda_level)
			flag("sda_level", 32'(w.sda_level), 32'(g.sda_level));
		if (g.sda_enable !== w.sda_enable)
			flag("sda_enable", 32'(w.sda_enable), 32'(g.sda_enable));
		if (g.busy_res !== w.busy_res) flag("busy_res", 32'(w.busy_res), 32'(g.busy_res));
		if (g.done_res !== w.done_res) flag("done_res", 32'(w.done_res), 32'(g.done_res));
		if (g.status !== w.status) flag("status", 32'(w.status), 32'(g.status));
		if (g.read_data !== w.read_data)
			flag("read_data", 32'(w.read_data), 32'(g.read_data));
	endtask

	// Predict on every accepted tick; compare every result transfer in order
	always @(posedge clk) begin : observe
		i2cra_out_t want;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			bus_tick(in_data, want);
			line_expect.push_back(want);
			taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (line_expect.size() == 0) begin
				faults++;
				$display("%0d ns: result transfer expected none, got %0h", $time, out_data);
			end else begin
				check_line(line_expect.pop_front(), out_data);
			end
			checked++;
		end
	end

	// Tick driver: hold a stalled transfer, otherwise idle in bursts or send the next tick
	always @(negedge clk) begin : drive
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				in_gap <= $urandom_range(0, 3);
				in_valid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				in_data <= pending_ticks.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure in short bursts
	always @(negedge clk) begin : back_pressure
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic sda_pick(input sda_habit_t h);
		case (h)
			ACK_EAGER: return ($urandom_range(0, 9) == 0);
			ACK_MIXED: return 1'($urandom_range(0, 1));
			ACK_LAZY:  return ($urandom_range(0, 19) != 0);
			default:   return 1'b1;
		endcase
	endfunction

	task automatic push_tick(input logic [1:0] k, input logic [6:0] s, input logic [15:0] r,
			input logic [7:0] v, input sda_habit_t h);
		i2cra_in_t t;
		t.kind = k;
		t.slave_addr = s;
		t.reg_addr = r;
		t.write_value = v;
		t.sda_in = sda_pick(h);
		pending_ticks.push_back(t);
		queued++;
	endtask

	// Plain ticks, noise_pct percent of them carrying a stray command
	task automatic push_quiet(input int n, input sda_habit_t h, input int noise_pct);
		logic [1:0] k;
		repeat (n) begin
			k = KIND_NONE;
			if ($urandom_range(0, 99) < noise_pct) k = 2'($urandom_range(1, 3));
			push_tick(k, 7'($urandom), 16'($urandom), 8'($urandom), h);
		end
	endtask

	// Keep ticking until the shadow sequencer is back in idle
	task automatic settle(input sda_habit_t h);
		while (1) begin
			wait (taken == queued);
			if (seq_step == 5'd0) break;
			push_quiet(8, h, 0);
		end
		wait (checked == taken);
	endtask

	task automatic one_command(input logic [1:0] k, input logic [6:0] s, input logic [15:0] r,
			input logic [7:0] v, input sda_habit_t h);
		push_tick(k, s, r, v, h);
		settle(h);
	endtask

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] a, output logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= a;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Set the acknowledge timeout, poke the unused slot, and read the value back
	task automatic tune_timeout(input logic [15:0] v);
		logic [31:0] rd;
		apb_write(ADDR_ACK_TIMEOUT, {16'd0, v});
		ack_limit = v;
		apb_write(REG_SPARE, $urandom);
		apb_read(ADDR_ACK_TIMEOUT, rd);
		if (rd[15:0] !== v) flag("ack_timeout", 32'(v), 32'(rd[15:0]));
	endtask

	initial begin : stimulus
		logic [31:0] rd;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_read(ADDR_ACK_TIMEOUT, rd);
		if (rd[15:0] !== ACK_TIMEOUT_RST)
			flag("ack_timeout", 32'(ACK_TIMEOUT_RST), 32'(rd[15:0]));

		// Address and data extremes on the first probe and write commands
		idle_pct = 15;
		stall_pct = 15;
		push_quiet(4, ACK_MIXED, 0);
		one_command(KIND_PROBE, 7'h7F, 16'hFFFF, 8'hFF, ACK_EAGER);
		one_command(KIND_WRITE, 7'h55, 16'hFFFF, 8'hFF, ACK_EAGER);
		// this read is taken; the probe below arrives mid transaction and is dropped
		push_tick(KIND_READ, 7'h00, 16'h5A5A, 8'h00, ACK_MIXED);
		push_quiet(12, ACK_MIXED, 0);
		push_tick(KIND_PROBE, 7'h7E, 16'h7FFE, 8'h7E, ACK_MIXED);
		settle(ACK_MIXED);

		// a zero timeout fails at once; a failed read leaves the last byte alone
		tune_timeout(16'd0);
		one_command(KIND_READ, 7'h11, 16'h1234, 8'h56, ACK_NONE);

		// Short timeout against a slow target, with no idling to the end
		tune_timeout(16'd3);
		calm = 1'b1;
		idle_pct = 0;
		stall_pct = 0;
		one_command(KIND_WRITE, 7'h2A, 16'h0000, 8'h00, ACK_LAZY);
		push_quiet(6, ACK_MIXED, 0);
		settle(ACK_MIXED);

		wait (checked == taken);
		repeat (10) @(posedge clk);
		if (faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
